// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on i_clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_pkg
// types, register indexes and mask tables of the brush stamp plotter
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int PIC_WIDTH  = 160;
    localparam int PIC_HEIGHT = 168;

    localparam logic [2:0] CFG_PATTERN    = 3'd0;
    localparam logic [2:0] CFG_LATE       = 3'd1;
    localparam logic [2:0] CFG_SCREEN_EN  = 3'd2;
    localparam logic [2:0] CFG_SCREEN_COL = 3'd3;
    localparam logic [2:0] CFG_PRIO_EN    = 3'd4;
    localparam logic [2:0] CFG_PRIO_VAL   = 3'd5;

    localparam logic [7:0] LFSR_TAPS = 8'hB8;
    localparam logic [7:0] LFSR_SEED = 8'h01;

    typedef struct packed {
        logic [7:0] centre_x;
        logic [7:0] centre_y;
    } t_in;

    typedef struct packed {
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       write_screen;
        logic       write_priority;
        logic [3:0] colour_out;
        logic [3:0] priority_out;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [7:0] pattern_code;
        logic       late_version;
        logic       screen_enable;
        logic [3:0] screen_colour;
        logic       priority_enable;
        logic [3:0] priority_value;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic keep;
        logic scan_last;
        logic pend_valid;
        logic out_free;
    } t_sts;

    function automatic logic [6:0] mask_start(input logic [2:0] size);
        logic [6:0] v;
        case (size)
            3'd0:    v = 7'd0;
            3'd1:    v = 7'd1;
            3'd2:    v = 7'd4;
            3'd3:    v = 7'd9;
            3'd4:    v = 7'd16;
            3'd5:    v = 7'd25;
            3'd6:    v = 7'd37;
            default: v = 7'd50;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] mask_row(input logic [6:0] idx);
        logic [15:0] v;
        case (idx)
            7'd0:  v = 16'h8000;
            7'd1:  v = 16'hE000;
            7'd2:  v = 16'hE000;
            7'd3:  v = 16'hE000;
            7'd4:  v = 16'h7000;
            7'd5:  v = 16'hF800;
            7'd6:  v = 16'hF800;
            7'd7:  v = 16'hF800;
            7'd8:  v = 16'h7000;
            7'd9:  v = 16'h3800;
            7'd10: v = 16'h7C00;
            7'd11: v = 16'hFE00;
            7'd12: v = 16'hFE00;
            7'd13: v = 16'hFE00;
            7'd14: v = 16'h7C00;
            7'd15: v = 16'h3800;
            7'd16: v = 16'h1C00;
            7'd17: v = 16'h7F00;
            7'd18: v = 16'hFF80;
            7'd19: v = 16'hFF80;
            7'd20: v = 16'hFF80;
            7'd21: v = 16'hFF80;
            7'd22: v = 16'hFF80;
            7'd23: v = 16'h7F00;
            7'd24: v = 16'h1C00;
            7'd25: v = 16'h0E00;
            7'd26: v = 16'h3F80;
            7'd27: v = 16'h7FC0;
            7'd28: v = 16'h7FC0;
            7'd29: v = 16'hFFE0;
            7'd30: v = 16'hFFE0;
            7'd31: v = 16'hFFE0;
            7'd32: v = 16'h7FC0;
            7'd33: v = 16'h7FC0;
            7'd34: v = 16'h3F80;
            7'd35: v = 16'h1F00;
            7'd36: v = 16'h0E00;
            7'd37: v = 16'h0F80;
            7'd38: v = 16'h3FE0;
            7'd39: v = 16'h7FF0;
            7'd40: v = 16'h7FF0;
            7'd41: v = 16'hFFF8;
            7'd42: v = 16'hFFF8;
            7'd43: v = 16'hFFF8;
            7'd44: v = 16'hFFF8;
            7'd45: v = 16'hFFF8;
            7'd46: v = 16'h7FF0;
            7'd47: v = 16'h7FF0;
            7'd48: v = 16'h3FE0;
            7'd49: v = 16'h0F80;
            7'd50: v = 16'h07C0;
            7'd51: v = 16'h1FF0;
            7'd52: v = 16'h3FF8;
            7'd53: v = 16'h7FFC;
            7'd54: v = 16'h7FFC;
            7'd55: v = 16'hFFFE;
            7'd56: v = 16'hFFFE;
            7'd57: v = 16'hFFFE;
            7'd58: v = 16'hFFFE;
            7'd59: v = 16'hFFFE;
            7'd60: v = 16'h7FFC;
            7'd61: v = 16'h7FFC;
            7'd62: v = 16'h3FF8;
            7'd63: v = 16'h1FF0;
            7'd64: v = 16'h07C0;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/bsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsp_ctrl
// sequencer: load a centre, scan the stamp cells, flush the held pixel
// ----------------------------------------------------------------------------
module bsp_ctrl
    import bsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_adv;

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign w_adv      = !(i_sts.keep && i_sts.pend_valid) || i_sts.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = w_adv;
                if (w_adv && i_sts.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/bsp_datapath.sv =====
// ----------------------------------------------------------------------------
// bsp_datapath
// start point clamp, cell counters, mask lookup, spray lfsr, one-pixel
// hold for the last flag and the output register
// ----------------------------------------------------------------------------
module bsp_datapath
    import bsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_cfg i_cfg,
    input  t_in  i_in,
    input  logic i_out_stall,
    output t_sts o_sts,
    output logic o_out_valid,
    output t_out o_out
);

    localparam logic signed [10:0] X_LIM_BASE = 11'(2 * PIC_WIDTH);
    localparam logic signed [9:0]  Y_LIM_BASE = 10'(PIC_HEIGHT - 1);

    logic [2:0]         w_n;
    logic               w_solid;
    logic               w_spray;
    logic               w_late;
    logic               w_plot;
    logic [3:0]         w_row_last;
    logic [1:0]         w_col_last;
    logic signed [10:0] w_px2;
    logic signed [10:0] w_xlim;
    logic signed [10:0] w_px2_c;
    logic signed [9:0]  w_py0;
    logic signed [9:0]  w_ylim;
    logic signed [9:0]  w_py_c;
    logic [15:0]        w_word;
    logic               w_bit;
    logic               w_cand;
    logic [7:0]         w_lfsr_next;
    logic               w_spray_ok;
    logic [9:0]         w_x;
    logic [8:0]         w_y;
    logic               w_inside;
    logic               w_keep;
    logic               w_out_free;
    logic               w_out_load;

    logic [8:0] r_px;
    logic [7:0] r_py;
    logic [3:0] r_row;
    logic [1:0] r_col;
    logic [7:0] r_lfsr;
    logic [7:0] r_pend_x;
    logic [7:0] r_pend_y;
    logic       r_pend_valid;
    logic       r_out_valid;
    t_out       r_out;

    assign w_n        = i_cfg.pattern_code[2:0];
    assign w_solid    = i_cfg.pattern_code[4];
    assign w_spray    = i_cfg.pattern_code[5];
    assign w_late     = i_cfg.late_version && (w_n == 3'd1);
    assign w_plot     = i_cfg.screen_enable || i_cfg.priority_enable;
    assign w_row_last = {w_n, 1'b0};
    assign w_col_last = w_n[2:1];

    // start point clamp
    assign w_px2  = $signed({2'b00, i_in.centre_x, 1'b0}) - $signed({8'd0, w_n});
    assign w_xlim = X_LIM_BASE - $signed({7'd0, w_n, 1'b0});
    assign w_py0  = $signed({2'b00, i_in.centre_y}) - $signed({7'd0, w_n});
    assign w_ylim = Y_LIM_BASE - $signed({6'd0, w_n, 1'b0});

    always_comb begin
        if (w_px2 < 0) begin
            w_px2_c = '0;
        end else if (w_px2 >= w_xlim) begin
            w_px2_c = w_xlim;
        end else begin
            w_px2_c = w_px2;
        end
        if (w_py0 < 0) begin
            w_py_c = '0;
        end else if (w_py0 >= w_ylim) begin
            w_py_c = w_ylim;
        end else begin
            w_py_c = w_py0;
        end
    end

    // current cell
    always_comb begin
        if (w_late) begin
            w_word = (r_row == 4'd1) ? 16'hE000 : 16'h0000;
        end else begin
            w_word = mask_row(mask_start(w_n) + {3'd0, r_row});
        end
    end

    assign w_bit       = w_word[4'd15 - {1'b0, r_col, 1'b0}];
    assign w_cand      = w_solid || w_bit;
    assign w_lfsr_next = {1'b0, r_lfsr[7:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 8'h00);
    assign w_spray_ok  = !w_spray || (w_lfsr_next[1:0] == 2'b01);
    assign w_x         = {1'b0, r_px} + {8'd0, r_col};
    assign w_y         = {1'b0, r_py} + {5'd0, r_row};
    assign w_inside    = (w_x < 10'(PIC_WIDTH)) && (w_y < 9'(PIC_HEIGHT));
    assign w_keep      = w_cand && w_spray_ok && w_inside && w_plot;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_out_load  = i_cmd.flush || (i_cmd.step && w_keep && r_pend_valid);

    assign o_sts.keep       = w_keep;
    assign o_sts.scan_last  = (r_row == w_row_last) && (r_col == w_col_last);
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_row        <= '0;
            r_col        <= '0;
            r_lfsr       <= LFSR_SEED;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_px         <= w_px2_c[9:1];
                r_py         <= w_py_c[7:0];
                r_row        <= '0;
                r_col        <= '0;
                r_lfsr       <= LFSR_SEED;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.step) begin
                if (w_spray && w_cand) begin
                    r_lfsr <= w_lfsr_next;
                end
                if (w_keep) begin
                    if (r_pend_valid) begin
                        r_out.pixel_x        <= r_pend_x;
                        r_out.pixel_y        <= r_pend_y;
                        r_out.write_screen   <= i_cfg.screen_enable;
                        r_out.write_priority <= i_cfg.priority_enable;
                        r_out.colour_out     <= i_cfg.screen_enable ? i_cfg.screen_colour
                                                                    : 4'd0;
                        r_out.priority_out   <= i_cfg.priority_enable ? i_cfg.priority_value
                                                                      : 4'd0;
                        r_out.last           <= 1'b0;
                    end
                    r_pend_x     <= w_x[7:0];
                    r_pend_y     <= w_y[7:0];
                    r_pend_valid <= 1'b1;
                end
                if (r_col == w_col_last) begin
                    r_col <= '0;
                    r_row <= r_row + 4'd1;
                end else begin
                    r_col <= r_col + 2'd1;
                end
            end
            if (i_cmd.flush) begin
                r_out.pixel_x        <= r_pend_x;
                r_out.pixel_y        <= r_pend_y;
                r_out.write_screen   <= i_cfg.screen_enable;
                r_out.write_priority <= i_cfg.priority_enable;
                r_out.colour_out     <= i_cfg.screen_enable ? i_cfg.screen_colour : 4'd0;
                r_out.priority_out   <= i_cfg.priority_enable ? i_cfg.priority_value : 4'd0;
                r_out.last           <= 1'b1;
                r_pend_valid         <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/brush_stamp_plotter.sv =====
// ----------------------------------------------------------------------------
// brush_stamp_plotter: one pen centre in, the run of stamp pixels out
// a centre is loaded, its (2n+1)*((n>>1)+1) stamp cells are scanned (n = pen size,
// at most 7) and a held pixel is flushed; one pixel per cycle while the output is not stalled
// a pixel is held until the next kept cell or the flush, then moves to the output register
// synchronous active-low reset clears the sequencer, valids and config registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brush_stamp_plotter
    import bsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PATTERN:    r_cfg.pattern_code    <= i_cfg_data;
                CFG_LATE:       r_cfg.late_version    <= i_cfg_data[0];
                CFG_SCREEN_EN:  r_cfg.screen_enable   <= i_cfg_data[0];
                CFG_SCREEN_COL: r_cfg.screen_colour   <= i_cfg_data[3:0];
                CFG_PRIO_EN:    r_cfg.priority_enable <= i_cfg_data[0];
                CFG_PRIO_VAL:   r_cfg.priority_value  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    bsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bsp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .i_in        (i_in_data),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

    `ASSERT_NEXT(a_busy_after_load, i_in_valid && !o_in_stall, o_in_stall, "not busy after load")
    `ASSERT_NEXT(a_flush_marks_last, w_cmd.flush, o_out_valid && o_out_data.last, "flush lost last")
    `ASSERT_NEXT(a_load_clears_hold, w_cmd.load, !w_sts.pend_valid, "held pixel survived load")
    `ASSERT_SAME(a_step_only_busy, w_cmd.step || w_cmd.flush, o_in_stall, "step while idle")

endmodule

// ===== bench/stamp_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// stamp_pixel_checker
// watches the centre, pixel and register channels of the brush stamp plotter,
// keeps its own copy of the registers, works out the pixel beats of every
// accepted centre and compares each pixel beat with the oldest one expected
// ----------------------------------------------------------------------------
module stamp_pixel_checker
    import bsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in        i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out       i_out_data,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PIXELS   = 60;
    localparam int SHOWN_ERRORS = 10;

    localparam int ROW_BASE [8] = '{0, 1, 4, 9, 16, 25, 37, 50};

    localparam logic [15:0] ROUND_ROWS [65] = '{
        16'h8000,
        16'hE000, 16'hE000, 16'hE000,
        16'h7000, 16'hF800, 16'hF800, 16'hF800, 16'h7000,
        16'h3800, 16'h7C00, 16'hFE00, 16'hFE00, 16'hFE00, 16'h7C00, 16'h3800,
        16'h1C00, 16'h7F00, 16'hFF80, 16'hFF80, 16'hFF80, 16'hFF80, 16'hFF80,
        16'h7F00, 16'h1C00,
        16'h0E00, 16'h3F80, 16'h7FC0, 16'h7FC0, 16'hFFE0, 16'hFFE0, 16'hFFE0,
        16'h7FC0, 16'h7FC0, 16'h3F80, 16'h1F00, 16'h0E00,
        16'h0F80, 16'h3FE0, 16'h7FF0, 16'h7FF0, 16'hFFF8, 16'hFFF8, 16'hFFF8,
        16'hFFF8, 16'hFFF8, 16'h7FF0, 16'h7FF0, 16'h3FE0, 16'h0F80,
        16'h07C0, 16'h1FF0, 16'h3FF8, 16'h7FFC, 16'h7FFC, 16'hFFFE, 16'hFFFE,
        16'hFFFE, 16'hFFFE, 16'hFFFE, 16'h7FFC, 16'h7FFC, 16'h3FF8, 16'h1FF0,
        16'h07C0
    };

    localparam logic [15:0] LATE_ROWS [3] = '{16'h0000, 16'hE000, 16'h0000};

    t_cfg regs;
    t_out stamp_pixels [$];
    t_out want;
    int   mismatches = 0;

    function automatic string describe(input t_out p);
        return $sformatf("x=%0d y=%0d scr=%0d pri=%0d col=%0d val=%0d last=%0d",
                         p.pixel_x, p.pixel_y, p.write_screen, p.write_priority,
                         p.colour_out, p.priority_out, p.last);
    endfunction

    function automatic void plot_stamp(input t_in centre);
        t_out        run [MAX_PIXELS];
        t_out        pix;
        int          cnt, size, rows, left, top, lim, r, col, x, y;
        logic        late_one, low;
        logic [15:0] word;
        logic [7:0]  lfsr;
        cnt      = 0;
        size     = int'(regs.pattern_code[2:0]);
        rows     = 2 * size + 1;
        late_one = regs.late_version && (size == 1);
        lfsr     = LFSR_SEED;

        left = 2 * int'(centre.centre_x) - size;
        if (left < 0) left = 0;
        lim = 2 * PIC_WIDTH - 2 * size;
        if (left > lim) left = lim;
        left = left / 2;

        top = int'(centre.centre_y) - size;
        if (top < 0) top = 0;
        lim = PIC_HEIGHT - 1 - 2 * size;
        if (top > lim) top = lim;

        for (r = 0; r < rows; r++) begin
            word = late_one ? LATE_ROWS[r % 3] : ROUND_ROWS[ROW_BASE[size] + r];
            for (col = 0; col <= rows; col += 4) begin
                if (!regs.pattern_code[4] && !word[15 - col / 2]) continue;
                if (regs.pattern_code[5]) begin
                    low  = lfsr[0];
                    lfsr = lfsr >> 1;
                    if (low) lfsr = lfsr ^ LFSR_TAPS;
                    if (lfsr[1:0] != 2'b01) continue;
                end
                x = left + col / 4;
                y = top + r;
                // off-picture pixels are dropped, the spray lfsr has already stepped
                if (x >= PIC_WIDTH || y >= PIC_HEIGHT) continue;
                if (!regs.screen_enable && !regs.priority_enable) continue;
                if (cnt >= MAX_PIXELS) continue;
                pix.pixel_x        = x[7:0];
                pix.pixel_y        = y[7:0];
                pix.write_screen   = regs.screen_enable;
                pix.write_priority = regs.priority_enable;
                pix.colour_out     = regs.screen_enable ? regs.screen_colour : 4'd0;
                pix.priority_out   = regs.priority_enable ? regs.priority_value : 4'd0;
                pix.last           = 1'b0;
                run[cnt] = pix;
                cnt++;
            end
        end
        if (cnt > 0) run[cnt - 1].last = 1'b1;
        for (r = 0; r < cnt; r++) stamp_pixels.push_back(run[r]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs = '0;
            stamp_pixels.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (stamp_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("unexpected pixel beat: %s", describe(i_out_data));
                end else begin
                    want = stamp_pixels.pop_front();
                    if (i_out_data.pixel_x !== want.pixel_x ||
                        i_out_data.pixel_y !== want.pixel_y ||
                        i_out_data.write_screen !== want.write_screen ||
                        i_out_data.write_priority !== want.write_priority ||
                        i_out_data.colour_out !== want.colour_out ||
                        i_out_data.priority_out !== want.priority_out ||
                        i_out_data.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= SHOWN_ERRORS)
                            $display("pixel beat mismatch: expected %s, got %s",
                                     describe(want), describe(i_out_data));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PATTERN:    regs.pattern_code    = i_cfg_data;
                    CFG_LATE:       regs.late_version    = i_cfg_data[0];
                    CFG_SCREEN_EN:  regs.screen_enable   = i_cfg_data[0];
                    CFG_SCREEN_COL: regs.screen_colour   = i_cfg_data[3:0];
                    CFG_PRIO_EN:    regs.priority_enable = i_cfg_data[0];
                    CFG_PRIO_VAL:   regs.priority_value  = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) plot_stamp(i_in_data);
        end
        o_fail_count = mismatches;
        o_pending    = stamp_pixels.size();
    end

endmodule

// ===== bench/brush_stamp_plotter_test.sv =====
// ----------------------------------------------------------------------------
// brush_stamp_plotter_test
// drives pen centres and register writes into the brush stamp plotter with
// random gaps and output stalls, first a directed set of stamps then random
// settings and centres; a side checker predicts every pixel beat
// ----------------------------------------------------------------------------
module brush_stamp_plotter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bsp_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int IDLE_PERCENT    = 21;
    localparam int RANDOM_PHASES   = 10;
    localparam int CALM_PHASE      = 4;
    localparam int ITEMS_PER_PHASE = 15;

    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in        in_data;
    logic       out_valid;
    logic       out_stall;
    t_out       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    logic       calm;
    int         phase, item;

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    brush_stamp_plotter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    stamp_pixel_checker pixel_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // wait for the last pixel beat, then idle through the settle period
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [7:0] pattern, input logic late,
                                 input logic scr_en, input logic [3:0] scr_col,
                                 input logic pri_en, input logic [3:0] pri_val);
        logic [7:0] noise;
        noise = 8'($urandom_range(0, 255));
        settle();
        write_reg(CFG_PATTERN, pattern);
        write_reg(CFG_LATE, {noise[7:1], late});
        write_reg(CFG_SCREEN_EN, {noise[6:0], scr_en});
        write_reg(CFG_SCREEN_COL, {noise[7:4], scr_col});
        write_reg(CFG_PRIO_EN, {noise[5:0], noise[7], pri_en});
        write_reg(CFG_PRIO_VAL, {noise[3:0], pri_val});
        write_reg(CFG_SPARE_LO, noise);
        write_reg(CFG_SPARE_HI, ~noise);
    endtask

    task automatic send_centre(input logic [7:0] x, input logic [7:0] y);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid         <= 1'b1;
        in_data.centre_x <= x;
        in_data.centre_y <= y;
        do @(posedge clk); while (in_stall);
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // both planes off after reset
        send_centre(8'd80, 8'd84);

        load_settings(8'h00, 1'b0, 1'b1, 4'hF, 1'b1, 4'h0);
        send_centre(8'd0, 8'd0);
        send_centre(8'd255, 8'd255);
        send_centre(8'd159, 8'd167);
        send_centre(8'd160, 8'd0);

        load_settings(8'h07, 1'b0, 1'b1, 4'hA, 1'b0, 4'h5);
        send_centre(8'd0, 8'd0);
        send_centre(8'd255, 8'd255);
        send_centre(8'd80, 8'd84);

        load_settings(8'h17, 1'b0, 1'b0, 4'h3, 1'b1, 4'hF);
        send_centre(8'd80, 8'd84);
        send_centre(8'd1, 8'd166);

        // alternate size one mask
        load_settings(8'h01, 1'b1, 1'b1, 4'h6, 1'b1, 4'h9);
        send_centre(8'd40, 8'd40);
        send_centre(8'd0, 8'd0);

        load_settings(8'h21, 1'b1, 1'b1, 4'hC, 1'b0, 4'h0);
        send_centre(8'd40, 8'd40);

        // spray drops the only pixel
        load_settings(8'h20, 1'b0, 1'b1, 4'h1, 1'b1, 4'h2);
        send_centre(8'd80, 8'd84);

        load_settings(8'hFF, 1'b1, 1'b0, 4'h0, 1'b1, 4'hF);
        send_centre(8'd80, 8'd84);
        send_centre(8'd255, 8'd0);

        load_settings(8'h17, 1'b0, 1'b0, 4'hF, 1'b0, 4'hF);
        send_centre(8'd80, 8'd84);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_settings(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          $urandom_range(99) < 80, 4'($urandom_range(0, 15)),
                          $urandom_range(99) < 80, 4'($urandom_range(0, 15)));
            calm = (phase == CALM_PHASE);
            for (item = 0; item < ITEMS_PER_PHASE; item++) begin
                if ($urandom_range(99) < 25)
                    send_centre(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else
                    send_centre(8'($urandom_range(0, PIC_WIDTH - 1)),
                                8'($urandom_range(0, PIC_HEIGHT - 1)));
            end
        end
        calm = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            if (pending != 0) $display("%0d pixel beats never arrived", pending);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
